>>> hdl/smstc_pkg.sv
// Shared widths, register indexes and defaults for the submatrix target-sum counter.
package smstc_pkg;

    // Fixed field widths
    localparam int ELEM_W     = 16;
    localparam int TARGET_W   = 32;
    localparam int DIM_CFG_W  = 7;
    localparam int COUNT_W    = 23;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Defaults for the top-level parameters
    localparam int DEFAULT_MAX_ROWS = 64;
    localparam int DEFAULT_MAX_COLS = 64;

    // Register reset values
    localparam logic [TARGET_W-1:0]  TARGET_RESET    = '0;
    localparam logic [DIM_CFG_W-1:0] ROW_COUNT_RESET = 7'd64;
    localparam logic [DIM_CFG_W-1:0] COL_COUNT_RESET = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 2'd2;

endpackage

>>> hdl/smstc_ifs.sv
// Valid/ready stream interfaces for matrix elements and match counts.
interface smstc_elem_if;
    logic                              valid;
    logic                              ready;
    logic signed [smstc_pkg::ELEM_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface smstc_count_if;
    logic                          valid;
    logic                          ready;
    logic [smstc_pkg::COUNT_W-1:0] match_count;

    modport source (output valid, output match_count, input ready);
    modport sink   (input valid, input match_count, output ready);
endinterface

>>> hdl/smstc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module smstc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then read old contents on the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/submatrix_sum_target_counter.sv
// Top level: loads a matrix, then counts submatrices whose sum equals the target.
//
// Usage: configure target_sum, row_count and col_count through the write port
// (index 0, 1, 2) while the block is idle. Stream the matrix in row-major order
// on element_ch, one element per cycle; ready is high whenever the block is
// loading. The transfer of the last element (rows * cols) starts the count and
// drops ready until the count is finished; one match_count transfer then follows
// on result_ch and the block returns to loading at position zero.
// Count steps, from the last element: for each of the rows*(rows+1)/2 row bands,
// add the bottom row into the column-sum memory, take one turnaround step, then
// walk all cols*(cols+1)/2 column runs; after the last band, drain and post the
// result. Every step is one read of the column-sum memory, so that memory port
// sets the count time.
// The result sits in an output register: the next matrix can load while it
// waits, but a finished count holds until the previous result is taken.
// Reset clears the registers to their defaults and the load position to zero;
// the matrix memory is not cleared and is written before it is read.
module submatrix_sum_target_counter #(
    parameter int MAX_ROWS = smstc_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = smstc_pkg::DEFAULT_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [smstc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smstc_pkg::CFG_DATA_W-1:0]    cfg_data,
    smstc_elem_if.sink                          element_ch,
    smstc_count_if.source                       result_ch
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CSUM_W = smstc_pkg::ELEM_W + $clog2(MAX_ROWS);
    localparam int RUN_W  = CSUM_W + $clog2(MAX_COLS);
    localparam int CMP_W  = (RUN_W > smstc_pkg::TARGET_W) ? RUN_W : smstc_pkg::TARGET_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_UPD,
        ST_UPD_LAST,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic signed [smstc_pkg::TARGET_W-1:0] target_reg;
    logic [smstc_pkg::DIM_CFG_W-1:0]       row_count_reg;
    logic [smstc_pkg::DIM_CFG_W-1:0]       col_count_reg;

    // Control and datapath registers
    state_t                         state_reg;
    logic [AW-1:0]                  lp_reg;
    logic [RI_W-1:0]                rows_last_reg;
    logic [CI_W-1:0]                cols_last_reg;
    logic [AW-1:0]                  cols_step_reg;
    logic [RI_W-1:0]                top_reg;
    logic [RI_W-1:0]                bot_reg;
    logic [AW-1:0]                  base_reg;
    logic [AW-1:0]                  top_base_reg;
    logic [CI_W-1:0]                c_reg;
    logic [CI_W-1:0]                s_reg;
    logic [CI_W-1:0]                e_reg;
    logic                           p_upd_vld_reg;
    logic                           p_upd_first_reg;
    logic [CI_W-1:0]                p_upd_col_reg;
    logic                           p_scan_vld_reg;
    logic                           p_scan_first_reg;
    logic signed [RUN_W-1:0]        run_reg;
    logic [smstc_pkg::COUNT_W-1:0]  count_reg;
    logic                           out_valid_reg;
    logic [smstc_pkg::COUNT_W-1:0]  out_count_reg;

    // Combinational signals
    logic [RDIM_W-1:0]       rows;
    logic [CDIM_W-1:0]       cols;
    logic [TOT_W-1:0]        total;
    logic                    in_xfer;
    logic                    last_elem;
    logic [AW-1:0]           mat_rd_addr;
    logic [smstc_pkg::ELEM_W-1:0] mat_rd_data;
    logic [CI_W-1:0]         cs_rd_addr;
    logic [CSUM_W-1:0]       cs_rd_data;
    logic signed [CSUM_W-1:0] cs_wr_data;
    logic signed [RUN_W-1:0] run_next;
    logic                    hit;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= smstc_pkg::TARGET_RESET;
            row_count_reg <= smstc_pkg::ROW_COUNT_RESET;
            col_count_reg <= smstc_pkg::COL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smstc_pkg::REG_TARGET_SUM: target_reg    <= cfg_data[smstc_pkg::TARGET_W-1:0];
                smstc_pkg::REG_ROW_COUNT:  row_count_reg <= cfg_data[smstc_pkg::DIM_CFG_W-1:0];
                smstc_pkg::REG_COL_COUNT:  col_count_reg <= cfg_data[smstc_pkg::DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp dimensions into 1..max and form the element total
    always_comb
    begin
        if (row_count_reg == '0)
            rows = RDIM_W'(1);
        else if (int'(row_count_reg) > MAX_ROWS)
            rows = RDIM_W'(MAX_ROWS);
        else
            rows = RDIM_W'(row_count_reg);

        if (col_count_reg == '0)
            cols = CDIM_W'(1);
        else if (int'(col_count_reg) > MAX_COLS)
            cols = CDIM_W'(MAX_COLS);
        else
            cols = CDIM_W'(col_count_reg);

        total = TOT_W'(rows) * TOT_W'(cols);
    end

    assign element_ch.ready = (state_reg == ST_LOAD);
    assign in_xfer          = element_ch.valid && (state_reg == ST_LOAD);
    assign last_elem        = (TOT_W'(lp_reg) + TOT_W'(1)) >= total;

    // Memory addresses
    assign mat_rd_addr = base_reg + AW'(c_reg);
    assign cs_rd_addr  = (state_reg == ST_SCAN) ? e_reg : c_reg;

    // Add the new row element into its column sum; a band's first row starts fresh
    assign cs_wr_data = (p_upd_first_reg ? CSUM_W'(0) : $signed(cs_rd_data))
                        + CSUM_W'($signed(mat_rd_data));

    // Extend the column run and compare against the target
    assign run_next = (p_scan_first_reg ? RUN_W'(0) : run_reg)
                      + RUN_W'($signed(cs_rd_data));
    assign hit      = (CMP_W'(run_next) == CMP_W'(target_reg));

    smstc_ram #(
        .WIDTH (smstc_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_matrix_ram (
        .clk     (clk),
        .wr_en   (in_xfer),
        .wr_addr (lp_reg),
        .wr_data (element_ch.element),
        .rd_addr (mat_rd_addr),
        .rd_data (mat_rd_data)
    );

    smstc_ram #(
        .WIDTH (CSUM_W),
        .DEPTH (MAX_COLS)
    ) u_colsum_ram (
        .clk     (clk),
        .wr_en   (p_upd_vld_reg),
        .wr_addr (p_upd_col_reg),
        .wr_data (cs_wr_data),
        .rd_addr (cs_rd_addr),
        .rd_data (cs_rd_data)
    );

    // Sequencer: load, band updates, run scans, result hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            lp_reg           <= '0;
            rows_last_reg    <= '0;
            cols_last_reg    <= '0;
            cols_step_reg    <= '0;
            top_reg          <= '0;
            bot_reg          <= '0;
            base_reg         <= '0;
            top_base_reg     <= '0;
            c_reg            <= '0;
            s_reg            <= '0;
            e_reg            <= '0;
            p_upd_vld_reg    <= 1'b0;
            p_upd_first_reg  <= 1'b0;
            p_upd_col_reg    <= '0;
            p_scan_vld_reg   <= 1'b0;
            p_scan_first_reg <= 1'b0;
            run_reg          <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_count_reg    <= '0;
        end
        else
        begin
            // Pipeline stage behind the memory reads
            p_upd_vld_reg    <= (state_reg == ST_UPD);
            p_upd_first_reg  <= (top_reg == bot_reg);
            p_upd_col_reg    <= c_reg;
            p_scan_vld_reg   <= (state_reg == ST_SCAN);
            p_scan_first_reg <= (e_reg == s_reg);

            if (p_scan_vld_reg)
            begin
                run_reg <= run_next;
                if (hit && (count_reg != smstc_pkg::COUNT_MAX))
                begin
                    count_reg <= count_reg + smstc_pkg::COUNT_W'(1);
                end
            end

            // Drop the result once transferred, unless a new count is posted now
            if (out_valid_reg && result_ch.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if (last_elem)
                        begin
                            lp_reg        <= '0;
                            rows_last_reg <= RI_W'(rows - RDIM_W'(1));
                            cols_last_reg <= CI_W'(cols - CDIM_W'(1));
                            cols_step_reg <= AW'(cols);
                            top_reg       <= '0;
                            bot_reg       <= '0;
                            base_reg      <= '0;
                            top_base_reg  <= '0;
                            c_reg         <= '0;
                            count_reg     <= '0;
                            state_reg     <= ST_UPD;
                        end
                        else
                        begin
                            lp_reg <= lp_reg + AW'(1);
                        end
                    end
                end

                ST_UPD:
                begin
                    if (c_reg == cols_last_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= ST_UPD_LAST;
                    end
                    else
                    begin
                        c_reg <= c_reg + CI_W'(1);
                    end
                end

                // Let the last column-sum write land before the scan reads it
                ST_UPD_LAST:
                begin
                    s_reg     <= '0;
                    e_reg     <= '0;
                    state_reg <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    if (e_reg != cols_last_reg)
                    begin
                        e_reg <= e_reg + CI_W'(1);
                    end
                    else if (s_reg != cols_last_reg)
                    begin
                        s_reg <= s_reg + CI_W'(1);
                        e_reg <= s_reg + CI_W'(1);
                    end
                    else if (bot_reg != rows_last_reg)
                    begin
                        // Extend the band one row down
                        bot_reg   <= bot_reg + RI_W'(1);
                        base_reg  <= base_reg + cols_step_reg;
                        state_reg <= ST_UPD;
                    end
                    else if (top_reg != rows_last_reg)
                    begin
                        // Start a new band at the next top row
                        top_reg      <= top_reg + RI_W'(1);
                        bot_reg      <= top_reg + RI_W'(1);
                        top_base_reg <= top_base_reg + cols_step_reg;
                        base_reg     <= top_base_reg + cols_step_reg;
                        state_reg    <= ST_UPD;
                    end
                    else
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end

                // Last run compare lands in the count this cycle
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end

                // Post the count once the output register is free
                ST_FINISH:
                begin
                    if (!out_valid_reg || result_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_count_reg <= count_reg;
                        state_reg     <= ST_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.match_count = out_count_reg;

endmodule
